@@ hdl/bmd_pkg.sv @@
`timescale 1ns / 1ps

package bmd_pkg;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int PHYS_W       = 21;
    localparam int RAM_BANK_W   = 8;
    localparam int ROM_BANK_W   = 5;
    localparam int BANK_CNT_W   = 9;

    localparam int ROM_BANKS_DEF = 32;

    localparam logic [BANK_CNT_W-1:0] RAM_BANK_COUNT_RST = 9'd256;

    localparam logic [ADDR_W-1:0] IO_BASE      = 16'h9F00;
    localparam logic [ADDR_W-1:0] HIRAM_BASE   = 16'hA000;
    localparam logic [ADDR_W-1:0] ROM_BASE     = 16'hC000;
    localparam logic [ADDR_W-1:0] BANKREG_MASK = 16'hFFFE;

    localparam logic [DATA_W-1:0] ROM_BANK_READ_SET = 8'(128 + 64 + 32);
    localparam logic [DATA_W-1:0] NOIO_READ_VALUE   = 8'h00;

    typedef enum logic [2:0] {
        TGT_LORAM   = 3'd0,
        TGT_HIRAM   = 3'd1,
        TGT_ROM     = 3'd2,
        TGT_CHIPA   = 3'd3,
        TGT_CHIPB   = 3'd4,
        TGT_VIDEO   = 3'd5,
        TGT_NOIO    = 3'd6,
        TGT_BANKREG = 3'd7
    } t_target;

    typedef struct packed {
        t_target                target;
        logic [PHYS_W-1:0]      phys_offset;
        logic                   write_enable;
        logic [DATA_W-1:0]      local_data;
        logic                   local_valid;
        logic                   ram_bank_load;
        logic                   rom_bank_load;
    } t_decode;

endpackage

@@ hdl/banked_memory_decoder_top.sv @@
`timescale 1ns / 1ps

// Bank-switched memory decoder for a 16-bit CPU bus.
// Input channel (i_in_valid / o_in_stall) carries one access word: read or
// write, address and write byte. Output channel (o_out_valid / i_out_stall)
// returns one decoded word per access: target, physical offset, write enable
// and the decoder's own read answer (bank registers, unmapped I/O).
// An access taken at an edge shows on the output after that edge. Throughput
// is one access per cycle while the output is not stalled; the decode is a
// single combinational pass between the input port and the output register.
// Writes to address 0 and 1 load the RAM and ROM bank registers; the next
// access already decodes with the new bank.
// Configuration: i_cfg_valid / o_cfg_ready writes the number of fitted RAM
// banks; o_cfg_ready is always high. Write it only while the block is idle.
// Reset (synchronous, active low) clears both banks to 0, sets the bank
// count to 256 and empties the output register.
// When the receiver stalls, the output word holds and o_in_stall rises
// while the output register is full, so no access is lost.
module banked_memory_decoder_top #(
    parameter int ROM_BANKS = bmd_pkg::ROM_BANKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmd_pkg::BANK_CNT_W-1:0]    i_cfg_ram_bank_count,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [bmd_pkg::ADDR_W-1:0]        i_address,
    input  logic [bmd_pkg::DATA_W-1:0]        i_write_data,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_target,
    output logic [bmd_pkg::PHYS_W-1:0]        o_phys_offset,
    output logic                              o_write_enable,
    output logic [bmd_pkg::DATA_W-1:0]        o_local_data,
    output logic                              o_local_valid
);
    import bmd_pkg::*;

    logic [BANK_CNT_W-1:0] r_ram_bank_count;
    logic [RAM_BANK_W-1:0] r_ram_bank;
    logic [ROM_BANK_W-1:0] r_rom_bank;
    logic                  r_out_valid;
    t_decode               r_out;

    t_decode               dec;
    logic                  in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    bmd_decode #(
        .ROM_BANKS (ROM_BANKS)
    ) u_decode (
        .i_wr             (i_req_type),
        .i_addr           (i_address),
        .i_ram_bank       (r_ram_bank),
        .i_rom_bank       (r_rom_bank),
        .i_ram_bank_count (r_ram_bank_count),
        .o_dec            (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_bank_count <= RAM_BANK_COUNT_RST;
            r_ram_bank       <= '0;
            r_rom_bank       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ram_bank_count <= i_cfg_ram_bank_count;
            end
            if (in_accept && dec.ram_bank_load) begin
                r_ram_bank <= i_write_data;
            end
            if (in_accept && dec.rom_bank_load) begin
                r_rom_bank <= i_write_data[ROM_BANK_W-1:0];
            end
            // drop the word once taken, refill on a new access
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= dec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target       = r_out.target;
    assign o_phys_offset  = r_out.phys_offset;
    assign o_write_enable = r_out.write_enable;
    assign o_local_data   = r_out.local_data;
    assign o_local_valid  = r_out.local_valid;

`ifndef SYNTHESIS
    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted access produced no output word");

    a_rom_never_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_target == TGT_ROM) |-> !o_write_enable)
        else $error("write enable on ROM target");

    a_local_only_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_local_valid) |->
            (o_target == TGT_BANKREG || o_target == TGT_NOIO) && !o_write_enable)
        else $error("local answer on a target the decoder does not own");

    a_rom_bank_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type && i_address == 16'd1) |=>
            r_rom_bank == $past(i_write_data[ROM_BANK_W-1:0]))
        else $error("ROM bank register not loaded");

    a_bank_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_ram_bank) && $stable(r_rom_bank))
        else $error("bank register changed without an access");
`endif

endmodule

@@ hdl/bmd_decode.sv @@
`timescale 1ns / 1ps

module bmd_decode #(
    parameter int ROM_BANKS = bmd_pkg::ROM_BANKS_DEF
) (
    input  logic                              i_wr,
    input  logic [bmd_pkg::ADDR_W-1:0]        i_addr,
    input  logic [bmd_pkg::RAM_BANK_W-1:0]    i_ram_bank,
    input  logic [bmd_pkg::ROM_BANK_W-1:0]    i_rom_bank,
    input  logic [bmd_pkg::BANK_CNT_W-1:0]    i_ram_bank_count,
    output bmd_pkg::t_decode                  o_dec
);
    import bmd_pkg::*;

    localparam int PAGE_W    = $clog2(ROM_BANKS);
    localparam int ROM_DEPTH = 2 ** ROM_BANK_W;

    // ROM bank to physical page; remainders are worked out at elaboration
    logic [PAGE_W-1:0] rom_page_tbl [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom_page
        assign rom_page_tbl[g] = PAGE_W'(g % ROM_BANKS);
    end

    logic [3:0] slot;
    assign slot = i_addr[7:4];

    always_comb begin
        o_dec               = '0;
        o_dec.target        = TGT_LORAM;
        o_dec.phys_offset   = PHYS_W'(i_addr);
        if (i_addr < IO_BASE) begin
            if ((i_addr & BANKREG_MASK) != '0) begin
                o_dec.target       = TGT_LORAM;
                o_dec.write_enable = i_wr;
            end else begin
                o_dec.target = TGT_BANKREG;
                if (i_wr) begin
                    o_dec.write_enable  = 1'b1;
                    o_dec.ram_bank_load = !i_addr[0];
                    o_dec.rom_bank_load = i_addr[0];
                end else begin
                    o_dec.local_valid = 1'b1;
                    o_dec.local_data  = i_addr[0] ? (ROM_BANK_READ_SET | DATA_W'(i_rom_bank))
                                                  : i_ram_bank;
                end
            end
        end else if (i_addr < HIRAM_BASE) begin
            case (slot) inside
                4'd0, 4'd1: begin
                    o_dec.target       = (slot == 4'd0) ? TGT_CHIPA : TGT_CHIPB;
                    o_dec.phys_offset  = PHYS_W'(i_addr[3:0]);
                    o_dec.write_enable = i_wr;
                end
                [4'd2:4'd3]: begin
                    o_dec.target       = TGT_VIDEO;
                    o_dec.phys_offset  = PHYS_W'(i_addr[4:0]);
                    o_dec.write_enable = i_wr;
                end
                default: begin
                    // unmapped slot: drop writes, read back a fixed byte
                    o_dec.target      = TGT_NOIO;
                    o_dec.phys_offset = PHYS_W'(i_addr[7:0]);
                    o_dec.local_valid = !i_wr;
                    o_dec.local_data  = NOIO_READ_VALUE;
                end
            endcase
        end else if (i_addr < ROM_BASE) begin
            o_dec.target       = TGT_HIRAM;
            o_dec.phys_offset  = {i_ram_bank, i_addr[12:0]};
            o_dec.write_enable = i_wr && ({1'b0, i_ram_bank} < i_ram_bank_count);
        end else begin
            o_dec.target      = TGT_ROM;
            o_dec.phys_offset = PHYS_W'({rom_page_tbl[i_rom_bank], i_addr[13:0]});
        end
    end

endmodule
